// ===== rtl/srtf_pkg.sv =====
`timescale 1ns / 1ps

package srtf_pkg;

  // field widths
  localparam int ID_W    = 16;
  localparam int TIME_W  = 20;
  localparam int BURST_W = 8;

  // default table depth
  localparam int MAX_PROCS_DEF = 16;

  // saturating clock ceiling
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  // command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // one process table entry as stored in RAM
  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [TIME_W-1:0]  arrival;
    logic [BURST_W-1:0] remaining;
  } entry_t;

  localparam int ENTRY_W = ID_W + TIME_W + BURST_W;

endpackage

// ===== rtl/srtf_ram.sv =====
`timescale 1ns / 1ps

module srtf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/srtf_tick_scheduler.sv =====
`timescale 1ns / 1ps

// Preemptive shortest-remaining-time-first scheduler.
// Input channel: a word is taken on a rising edge with start high and busy
// low. in_command selects a load (store id, arrival, burst in the next free
// slot) or a tick (run one scheduling step).
// A load gives no result and leaves busy low; loads into a
// full table or with a zero burst are dropped.
// A tick raises busy while the table is scanned and the winner committed:
// the table RAM is read one slot per cycle through its single read port and
// each word goes through one shared compare unit, then the ST_DONE state
// commits the winner. The result word is on the out_ ports in the first
// cycle with busy low; the next word can be taken at the edge that takes
// that result.
// Result channel: out_strobe is high for exactly one cycle with the word on
// the out_ ports; the receiver cannot stall it, so nothing is buffered.
// Reset (rst_n, synchronous, active low) empties the table and clears the
// internal clock and completion count; no clearing pass is needed since
// only words from loaded slots are ever used.
module srtf_tick_scheduler #(
  parameter int MAX_PROCS = srtf_pkg::MAX_PROCS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_command,
  input  logic [srtf_pkg::ID_W-1:0]    in_proc_id,
  input  logic [srtf_pkg::TIME_W-1:0]  in_arrival_time,
  input  logic [srtf_pkg::BURST_W-1:0] in_burst_time,
  output logic                        out_strobe,
  output logic                        out_idle,
  output logic [srtf_pkg::ID_W-1:0]    out_ran_id,
  output logic [srtf_pkg::TIME_W-1:0]  out_tick_time,
  output logic                        out_first_run,
  output logic [srtf_pkg::TIME_W-1:0]  out_response_time,
  output logic                        out_finished,
  output logic [srtf_pkg::TIME_W-1:0]  out_finish_time,
  output logic                        out_all_done
);

  import srtf_pkg::*;

  localparam int IDX_W = $clog2(MAX_PROCS);
  localparam int CNT_W = $clog2(MAX_PROCS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PROCS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]           state_r, state_nxt;
  logic [CNT_W-1:0]     loaded_r, loaded_nxt;
  logic [CNT_W-1:0]     completed_r, completed_nxt;
  logic [TIME_W-1:0]    clock_r, clock_nxt;
  logic [MAX_PROCS-1:0] started_r, started_nxt;
  logic [MAX_PROCS-1:0] done_r, done_nxt;

  // scan pointer and read pipeline tag
  logic [CNT_W-1:0]     idx_r, idx_nxt;
  logic                 pend_r, pend_nxt;
  logic [IDX_W-1:0]     pend_idx_r, pend_idx_nxt;
  logic [TIME_W-1:0]    tick_t_r, tick_t_nxt;

  // running best candidate
  logic                 best_vld_r, best_vld_nxt;
  entry_t               best_r, best_nxt;
  logic [IDX_W-1:0]     best_slot_r, best_slot_nxt;

  // result registers
  logic                 strobe_r, strobe_nxt;
  logic                 idle_r, idle_nxt;
  logic [ID_W-1:0]      ran_id_r, ran_id_nxt;
  logic [TIME_W-1:0]    tick_time_r, tick_time_nxt;
  logic                 first_r, first_nxt;
  logic [TIME_W-1:0]    resp_r, resp_nxt;
  logic                 fin_r, fin_nxt;
  logic [TIME_W-1:0]    ftime_r, ftime_nxt;
  logic                 all_done_r, all_done_nxt;

  // RAM port signals
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  entry_t               ram_wdata;
  logic [IDX_W-1:0]     ram_raddr;
  logic [ENTRY_W-1:0]   ram_rdata;
  entry_t               rd_entry;

  logic                 accept;
  logic                 cand_ok;
  logic                 cand_better;
  logic [BURST_W-1:0]   rem_dec;

  assign accept    = start && (state_r == ST_IDLE);
  assign ram_raddr = idx_r[IDX_W-1:0];
  assign rd_entry  = entry_t'(ram_rdata);
  assign rem_dec   = best_r.remaining - BURST_W'(1);

  srtf_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAX_PROCS)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ENTRY_W'(ram_wdata)),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // shared compare unit: runnable and better than current best
  always_comb begin
    cand_ok = pend_r && !done_r[pend_idx_r] && (rd_entry.arrival <= tick_t_r);
    cand_better = !best_vld_r
               || (rd_entry.remaining < best_r.remaining)
               || ((rd_entry.remaining == best_r.remaining)
                   && (rd_entry.arrival < best_r.arrival));
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    loaded_nxt    = loaded_r;
    completed_nxt = completed_r;
    clock_nxt     = clock_r;
    started_nxt   = started_r;
    done_nxt      = done_r;
    idx_nxt       = idx_r;
    pend_nxt      = 1'b0;
    pend_idx_nxt  = idx_r[IDX_W-1:0];
    tick_t_nxt    = tick_t_r;
    best_vld_nxt  = best_vld_r;
    best_nxt      = best_r;
    best_slot_nxt = best_slot_r;
    strobe_nxt    = 1'b0;
    idle_nxt      = idle_r;
    ran_id_nxt    = ran_id_r;
    tick_time_nxt = tick_time_r;
    first_nxt     = first_r;
    resp_nxt      = resp_r;
    fin_nxt       = fin_r;
    ftime_nxt     = ftime_r;
    all_done_nxt  = all_done_r;
    ram_we        = 1'b0;
    ram_waddr     = loaded_r[IDX_W-1:0];
    ram_wdata     = '{id: in_proc_id, arrival: in_arrival_time, remaining: in_burst_time};

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_command == CMD_LOAD) begin
            if ((loaded_r < CNT_MAX) && (in_burst_time != '0)) begin
              ram_we = 1'b1;
              started_nxt[loaded_r[IDX_W-1:0]] = 1'b0;
              done_nxt[loaded_r[IDX_W-1:0]]    = 1'b0;
              loaded_nxt = loaded_r + CNT_W'(1);
            end
          end else begin
            state_nxt    = ST_SCAN;
            idx_nxt      = '0;
            tick_t_nxt   = clock_r;
            best_vld_nxt = 1'b0;
          end
        end
      end

      ST_SCAN: begin
        // fold the word read last cycle into the running best
        if (cand_ok && cand_better) begin
          best_vld_nxt  = 1'b1;
          best_nxt      = rd_entry;
          best_slot_nxt = pend_idx_r;
        end
        if (idx_r < loaded_r) begin
          pend_nxt = 1'b1;
          idx_nxt  = idx_r + CNT_W'(1);
        end else begin
          state_nxt = ST_DONE;
        end
      end

      ST_DONE: begin
        strobe_nxt    = 1'b1;
        tick_time_nxt = tick_t_r;
        idle_nxt      = !best_vld_r;
        ran_id_nxt    = '0;
        first_nxt     = 1'b0;
        resp_nxt      = '0;
        fin_nxt       = 1'b0;
        ftime_nxt     = '0;
        if (best_vld_r) begin
          ran_id_nxt = best_r.id;
          ram_we     = 1'b1;
          ram_waddr  = best_slot_r;
          ram_wdata  = '{id: best_r.id, arrival: best_r.arrival, remaining: rem_dec};
          if (!started_r[best_slot_r]) begin
            started_nxt[best_slot_r] = 1'b1;
            first_nxt = 1'b1;
            resp_nxt  = tick_t_r - best_r.arrival;
          end
          if (rem_dec == '0) begin
            done_nxt[best_slot_r] = 1'b1;
            completed_nxt = completed_r + CNT_W'(1);
            fin_nxt       = 1'b1;
            ftime_nxt     = (tick_t_r == TIME_MAX) ? TIME_MAX : tick_t_r + TIME_W'(1);
          end
        end
        all_done_nxt = (completed_nxt == loaded_r);
        if (clock_r != TIME_MAX) begin
          clock_nxt = clock_r + TIME_W'(1);
        end
        state_nxt = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      loaded_r    <= '0;
      completed_r <= '0;
      clock_r     <= '0;
      started_r   <= '0;
      done_r      <= '0;
      pend_r      <= 1'b0;
      best_vld_r  <= 1'b0;
      strobe_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      loaded_r    <= loaded_nxt;
      completed_r <= completed_nxt;
      clock_r     <= clock_nxt;
      started_r   <= started_nxt;
      done_r      <= done_nxt;
      pend_r      <= pend_nxt;
      best_vld_r  <= best_vld_nxt;
      strobe_r    <= strobe_nxt;
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    pend_idx_r  <= pend_idx_nxt;
    tick_t_r    <= tick_t_nxt;
    best_r      <= best_nxt;
    best_slot_r <= best_slot_nxt;
    idle_r      <= idle_nxt;
    ran_id_r    <= ran_id_nxt;
    tick_time_r <= tick_time_nxt;
    first_r     <= first_nxt;
    resp_r      <= resp_nxt;
    fin_r       <= fin_nxt;
    ftime_r     <= ftime_nxt;
    all_done_r  <= all_done_nxt;
  end

  assign busy              = (state_r != ST_IDLE);
  assign out_strobe        = strobe_r;
  assign out_idle          = idle_r;
  assign out_ran_id        = ran_id_r;
  assign out_tick_time     = tick_time_r;
  assign out_first_run     = first_r;
  assign out_response_time = resp_r;
  assign out_finished      = fin_r;
  assign out_finish_time   = ftime_r;
  assign out_all_done      = all_done_r;

endmodule

// ===== sim/srtf_tick_scheduler_test.sv =====
`timescale 1ns / 1ps

module srtf_tick_scheduler_test;
  import srtf_pkg::*;

  localparam int RANDOM_WORDS = 1740;
  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 40;

  // one word on the input channel
  typedef struct packed {
    logic               command;
    logic [ID_W-1:0]    proc_id;
    logic [TIME_W-1:0]  arrival;
    logic [BURST_W-1:0] burst;
  } sched_word_t;

  // one tick report on the result channel
  typedef struct packed {
    logic              idle;
    logic [ID_W-1:0]   ran_id;
    logic [TIME_W-1:0] tick_time;
    logic              first_run;
    logic [TIME_W-1:0] resp_time;
    logic              finished;
    logic [TIME_W-1:0] fin_time;
    logic              all_done;
  } sched_report_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic                in_command = CMD_LOAD;
  logic [ID_W-1:0]     in_proc_id = '0;
  logic [TIME_W-1:0]   in_arrival_time = '0;
  logic [BURST_W-1:0]  in_burst_time = '0;
  logic                out_strobe;
  logic                out_idle;
  logic [ID_W-1:0]     out_ran_id;
  logic [TIME_W-1:0]   out_tick_time;
  logic                out_first_run;
  logic [TIME_W-1:0]   out_response_time;
  logic                out_finished;
  logic [TIME_W-1:0]   out_finish_time;
  logic                out_all_done;

  srtf_tick_scheduler dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_proc_id       (in_proc_id),
    .in_arrival_time  (in_arrival_time),
    .in_burst_time    (in_burst_time),
    .out_strobe       (out_strobe),
    .out_idle         (out_idle),
    .out_ran_id       (out_ran_id),
    .out_tick_time    (out_tick_time),
    .out_first_run    (out_first_run),
    .out_response_time(out_response_time),
    .out_finished     (out_finished),
    .out_finish_time  (out_finish_time),
    .out_all_done     (out_all_done)
  );

  // predicted scheduler state
  entry_t            proc_tbl     [MAX_PROCS_DEF];
  bit                proc_started [MAX_PROCS_DEF];
  bit                proc_done    [MAX_PROCS_DEF];
  int                n_loaded = 0;
  int                n_completed = 0;
  logic [TIME_W-1:0] sched_clock = '0;

  sched_word_t   word_q[$];
  sched_report_t report_q[$];

  // stimulus bookkeeping
  int words_queued = 0;
  int words_taken = 0;
  int gen_clock = 0;
  int gen_loaded = 0;

  bit word_taken = 1'b0;
  int stall_cycles = 0;
  int mismatches = 0;
  int gap_left = 0;
  int calm_left = 0;
  bit timed_out = 1'b0;

  // store a process the way the block does; zero bursts and a full table drop it
  function automatic void store_process(logic [ID_W-1:0] id, logic [TIME_W-1:0] arr,
                                        logic [BURST_W-1:0] burst);
    if (n_loaded < MAX_PROCS_DEF && burst != '0) begin
      proc_tbl[n_loaded].id        = id;
      proc_tbl[n_loaded].arrival   = arr;
      proc_tbl[n_loaded].remaining = burst;
      proc_started[n_loaded]       = 1'b0;
      proc_done[n_loaded]          = 1'b0;
      n_loaded++;
    end
  endfunction

  // one scheduling step: pick least remaining, then earliest arrival, then lowest slot
  function automatic sched_report_t run_tick();
    int best;
    sched_report_t rpt;
    best = -1;
    rpt = '0;
    rpt.idle = 1'b1;
    rpt.tick_time = sched_clock;
    for (int i = 0; i < n_loaded; i++) begin
      if (!proc_done[i] && proc_tbl[i].arrival <= sched_clock) begin
        if (best < 0 || proc_tbl[i].remaining < proc_tbl[best].remaining ||
            (proc_tbl[i].remaining == proc_tbl[best].remaining &&
             proc_tbl[i].arrival < proc_tbl[best].arrival))
          best = i;
      end
    end
    if (best >= 0) begin
      rpt.idle = 1'b0;
      rpt.ran_id = proc_tbl[best].id;
      if (!proc_started[best]) begin
        proc_started[best] = 1'b1;
        rpt.first_run = 1'b1;
        rpt.resp_time = sched_clock - proc_tbl[best].arrival;
      end
      if (proc_tbl[best].remaining != '0)
        proc_tbl[best].remaining = proc_tbl[best].remaining - 1'b1;
      if (proc_tbl[best].remaining == '0) begin
        proc_done[best] = 1'b1;
        n_completed++;
        rpt.finished = 1'b1;
        rpt.fin_time = (sched_clock == TIME_MAX) ? TIME_MAX : sched_clock + 1'b1;
      end
    end
    if (sched_clock != TIME_MAX)
      sched_clock = sched_clock + 1'b1;
    rpt.all_done = (n_completed == n_loaded);
    return rpt;
  endfunction

  task automatic add_load(input logic [ID_W-1:0] id, input logic [TIME_W-1:0] arr,
                          input logic [BURST_W-1:0] burst);
    sched_word_t w;
    w.command = CMD_LOAD;
    w.proc_id = id;
    w.arrival = arr;
    w.burst   = burst;
    word_q = {word_q, w};
    words_queued++;
    if (gen_loaded < MAX_PROCS_DEF && burst != '0)
      gen_loaded++;
  endtask

  // unused fields of a tick carry random bits
  task automatic add_tick();
    sched_word_t w;
    w.command = CMD_TICK;
    w.proc_id = ID_W'($urandom);
    w.arrival = TIME_W'($urandom);
    w.burst   = BURST_W'($urandom);
    word_q = {word_q, w};
    words_queued++;
    gen_clock++;
  endtask

  initial begin
    forever #10 clk = ~clk;
  end

  // driver: new word or gap at the falling edge, held until taken
  always @(negedge clk) begin
    sched_word_t w;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!(start && !word_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (word_q.size() != 0) begin
        w = word_q.pop_front();
        in_command      <= w.command;
        in_proc_id      <= w.proc_id;
        in_arrival_time <= w.arrival;
        in_burst_time   <= w.burst;
        start           <= 1'b1;
        // mostly back to back or short gaps, a few long ones, some calm stretches
        if (calm_left == 0 && $urandom_range(0, 199) == 0)
          calm_left = 100;
        if (calm_left > 0) begin
          calm_left--;
          gap_left = 0;
        end else begin
          case ($urandom_range(0, 99)) inside
            [0:49]:  gap_left = 0;
            [50:84]: gap_left = $urandom_range(1, 3);
            [85:96]: gap_left = $urandom_range(4, 15);
            default: gap_left = $urandom_range(20, 60);
          endcase
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: take input words into the predictor, check reports
  always @(posedge clk) begin
    sched_report_t want;
    sched_report_t got;
    sched_report_t pred;
    if (!rst_n) begin
      word_taken = 1'b0;
      stall_cycles = 0;
    end else begin
      word_taken = start && !busy;
      if (word_taken) begin
        words_taken++;
        if (in_command == CMD_TICK) begin
          pred = run_tick();
          report_q = {report_q, pred};
        end else begin
          store_process(in_proc_id, in_arrival_time, in_burst_time);
        end
      end
      if (out_strobe) begin
        got.idle      = out_idle;
        got.ran_id    = out_ran_id;
        got.tick_time = out_tick_time;
        got.first_run = out_first_run;
        got.resp_time = out_response_time;
        got.finished  = out_finished;
        got.fin_time  = out_finish_time;
        got.all_done  = out_all_done;
        if (report_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: report with none expected, id=%h t=%0d", $realtime,
                     got.ran_id, got.tick_time);
        end else begin
          want = report_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: exp idle=%b id=%h t=%0d first=%b resp=%0d fin=%b ft=%0d done=%b",
                       $realtime, want.idle, want.ran_id, want.tick_time, want.first_run,
                       want.resp_time, want.finished, want.fin_time, want.all_done);
              $display("%0t: got idle=%b id=%h t=%0d first=%b resp=%0d fin=%b ft=%0d done=%b",
                       $realtime, got.idle, got.ran_id, got.tick_time, got.first_run,
                       got.resp_time, got.finished, got.fin_time, got.all_done);
            end
          end
        end
      end
      if (word_taken || out_strobe)
        stall_cycles = 0;
      else
        stall_cycles++;
    end
  end

  initial begin
    int load_gap;
    logic [TIME_W-1:0] arr;
    logic [BURST_W-1:0] burst;

    // directed: empty table, dropped load, ties, preemption by a short job
    add_tick();
    add_load(16'hFFFF, TIME_MAX, 8'd0);
    add_tick();
    add_load(16'h0000, 20'd0, 8'd3);
    add_load(16'hFFFF, 20'd1, 8'd3);
    add_load(16'h1234, 20'd0, 8'd3);
    add_tick();
    add_load(16'h00AA, TIME_W'(gen_clock), 8'd1);
    repeat (9) add_tick();
    add_tick();
    add_load(16'h5555, TIME_W'(gen_clock + 2), 8'd255);
    add_tick();

    // random: ticks with loads spread out until the table fills, a little noise
    load_gap = $urandom_range(30, 150);
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (gen_loaded < MAX_PROCS_DEF && load_gap == 0) begin
        case ($urandom_range(0, 9))
          0:       arr = TIME_W'($urandom);
          1, 2:    arr = TIME_W'($urandom_range(0, gen_clock));
          default: arr = TIME_W'(gen_clock + $urandom_range(0, 40));
        endcase
        case ($urandom_range(0, 9))
          0:       burst = 8'd1;
          1:       burst = 8'd255;
          default: burst = BURST_W'($urandom_range(1, 255));
        endcase
        add_load(ID_W'($urandom), arr, burst);
        load_gap = $urandom_range(30, 150);
      end else if ($urandom_range(0, 99) < 3) begin
        // dropped load: zero burst, or anything once the table is full
        add_load(ID_W'($urandom), TIME_W'($urandom),
                 (gen_loaded < MAX_PROCS_DEF) ? 8'd0 : 8'($urandom));
      end else begin
        add_tick();
      end
      if (load_gap > 0)
        load_gap--;
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // wait for every word and report, with a stall watchdog
    while (!timed_out && (words_taken < words_queued || report_q.size() != 0)) begin
      @(negedge clk);
      if (stall_cycles >= STALL_LIMIT)
        timed_out = 1'b1;
    end
    if (!timed_out)
      repeat (DRAIN_CYCLES) @(negedge clk);
    if (report_q.size() != 0)
      mismatches++;

    if (!timed_out && mismatches == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/srtf_pkg.sv
rtl/srtf_ram.sv
rtl/srtf_tick_scheduler.sv
sim/srtf_tick_scheduler_test.sv
